[hw/rtl/e2q_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and the arctangent table for the
// roll/pitch/yaw to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  // field widths
  localparam int ANGLE_W = 17;
  localparam int QUAT_W  = 16;
  localparam int Z_W     = 34;   // cordic datapath, Q2.30 plus guard bits
  localparam int TRIG_W  = 32;   // cosine / sine handed to the multiplier

  // parameter defaults
  localparam int OUT_FRAC_BITS_DEF   = 14;
  localparam int TRIG_ITERATIONS_DEF = 16;

  // angle codes: the half angle has a period of a full turn of codes
  localparam int FULL_TURN_CODES    = 92160;
  localparam int QUARTER_TURN_CODES = 23040;
  localparam int EIGHTH_TURN_CODES  = 11520;
  localparam int HALF_TURN_HALF     = 23040;   // rounding offset for /46080

  // pi in Q30 split as 46080 * PI_INT + PI_FRAC
  localparam int PI_INT  = 73204;
  localparam int PI_FRAC = 19106;

  // floor(v / 45) as (v * RECIP45) >> RECIP_SH, exact for v < 2^18
  localparam int RECIP45  = 372828;
  localparam int RECIP_SH = 24;

  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

  // pipeline depths outside the cordic
  localparam int REDUCE_LAT = 4;
  localparam int QUAT_LAT   = 3;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  // rounded arctangent of 2^-k in Q30
  function automatic longint atan_q30(input int k);
    longint r;
    case (k)
      0:  r = 843314857;
      1:  r = 497837829;
      2:  r = 263043837;
      3:  r = 133525159;
      4:  r = 67021687;
      5:  r = 33543516;
      6:  r = 16775851;
      7:  r = 8388437;
      8:  r = 4194283;
      9:  r = 2097149;
      10: r = 1048576;
      11: r = 524288;
      12: r = 262144;
      13: r = 131072;
      14: r = 65536;
      15: r = 32768;
      16: r = 16384;
      17: r = 8192;
      18: r = 4096;
      19: r = 2048;
      20: r = 1024;
      21: r = 512;
      22: r = 256;
      23: r = 128;
      24: r = 64;
      25: r = 32;
      26: r = 16;
      27: r = 8;
      28: r = 4;
      29: r = 2;
      30: r = 1;
      default: r = 0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/euler_to_quaternion_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// Roll, pitch and yaw in 1/128 degree to a unit quaternion in Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one angle triple per
//   item; output channel (out_valid_o / out_ready_i) returns one item of
//   quat_w/x/y/z per input item, in order.
//   The pipeline has four stages of angle folding, one cordic stage per
//   iteration plus a quadrant stage, and three multiply / round stages
//   ending in the output register.
//   Throughput is one item per cycle while the receiver takes results.
//   The whole pipeline advances together; when a result sits in the
//   output register and out_ready_i is low, every stage holds and
//   in_ready_o drops, so nothing is lost or repeated. Empty slots in the
//   pipeline move along while the output register is free.
//   Reset clears all valid bits; the block keeps no other state and
//   accepts an item in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module euler_to_quaternion_core #(
  parameter int OUT_FRAC_BITS   = e2q_pkg::OUT_FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  roll_deg_i,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  pitch_deg_i,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  yaw_deg_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_w_o,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_x_o,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_y_o,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_z_o
);

  localparam int LAT = e2q_pkg::REDUCE_LAT + TRIG_ITERATIONS + 1 + e2q_pkg::QUAT_LAT;
  localparam logic signed [e2q_pkg::QUAT_W-1:0] Q_HI =
    (OUT_FRAC_BITS >= 15) ? 16'sd32767 : e2q_pkg::QUAT_W'(32'sd1 <<< OUT_FRAC_BITS);
  localparam logic signed [e2q_pkg::QUAT_W-1:0] Q_LO =
    (OUT_FRAC_BITS >= 15) ? -16'sd32768 : -Q_HI;

  logic           en;
  logic [LAT-1:0] vld_q;

  // global advance: stall only when the output register is held
  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  // valid bits travel alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // angle folding, one unit per axis
  logic signed [e2q_pkg::Z_W-1:0] z_roll, z_pitch, z_yaw;
  logic [1:0]                     q_roll, q_pitch, q_yaw;

  e2q_angle_reduce u_red_roll (
    .clk_i, .en_i(en), .angle_i(roll_deg_i), .z_o(z_roll), .quad_o(q_roll)
  );
  e2q_angle_reduce u_red_pitch (
    .clk_i, .en_i(en), .angle_i(pitch_deg_i), .z_o(z_pitch), .quad_o(q_pitch)
  );
  e2q_angle_reduce u_red_yaw (
    .clk_i, .en_i(en), .angle_i(yaw_deg_i), .z_o(z_yaw), .quad_o(q_yaw)
  );

  // half-angle cosine and sine
  e2q_pkg::trig_t t_roll, t_pitch, t_yaw;

  e2q_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic_roll (
    .clk_i, .en_i(en), .z_i(z_roll), .quad_i(q_roll), .trig_o(t_roll)
  );
  e2q_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic_pitch (
    .clk_i, .en_i(en), .z_i(z_pitch), .quad_i(q_pitch), .trig_o(t_pitch)
  );
  e2q_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic_yaw (
    .clk_i, .en_i(en), .z_i(z_yaw), .quad_i(q_yaw), .trig_o(t_yaw)
  );

  // quaternion products and output register
  e2q_quat_mult #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_quat (
    .clk_i,
    .en_i    (en),
    .roll_i  (t_roll),
    .pitch_i (t_pitch),
    .yaw_i   (t_yaw),
    .quat_w_o,
    .quat_x_o,
    .quat_y_o,
    .quat_z_o
  );

  // an accepted item always enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item did not enter the pipeline");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output register");

  // every delivered component lies inside the clamp range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quat_w_o <= Q_HI && quat_w_o >= Q_LO && quat_x_o <= Q_HI &&
                    quat_x_o >= Q_LO && quat_y_o <= Q_HI && quat_y_o >= Q_LO &&
                    quat_z_o <= Q_HI && quat_z_o >= Q_LO)
    else $error("quaternion component outside clamp range");

endmodule

[hw/rtl/e2q_angle_reduce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_angle_reduce
// Folds a 1/128-degree angle code into a quadrant and a residual
// half angle in Q2.30 radians. Four register stages.
// ----------------------------------------------------------------------------
module e2q_angle_reduce (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle_i,
  output logic signed [e2q_pkg::Z_W-1:0]      z_o,
  output logic [1:0]                          quad_o
);

  // stage 1: wrap into one period, split into quadrant and remainder
  logic signed [17:0] code_ext;
  logic signed [17:0] u_ext;
  logic [16:0]        u;
  logic [2:0]         q4;
  logic [16:0]        off;
  logic signed [17:0] r;
  logic signed [17:0] r_abs;
  logic [13:0]        mag_d, mag_q;
  logic               neg_d, neg_q1, neg_q2, neg_q3;
  logic [1:0]         quad_q1, quad_q2, quad_q3;

  assign code_ext = 18'(angle_i);
  assign u_ext    = code_ext[17] ? code_ext + 18'(e2q_pkg::FULL_TURN_CODES) : code_ext;
  assign u        = u_ext[16:0];

  always_comb begin
    if (u < 17'(e2q_pkg::EIGHTH_TURN_CODES)) begin
      q4 = 3'd0;
    end else if (u < 17'(e2q_pkg::EIGHTH_TURN_CODES + e2q_pkg::QUARTER_TURN_CODES)) begin
      q4 = 3'd1;
    end else if (u < 17'(e2q_pkg::EIGHTH_TURN_CODES + 2 * e2q_pkg::QUARTER_TURN_CODES)) begin
      q4 = 3'd2;
    end else if (u < 17'(e2q_pkg::EIGHTH_TURN_CODES + 3 * e2q_pkg::QUARTER_TURN_CODES)) begin
      q4 = 3'd3;
    end else begin
      q4 = 3'd4;
    end
  end

  always_comb begin
    case (q4)
      3'd0:    off = 17'd0;
      3'd1:    off = 17'(e2q_pkg::QUARTER_TURN_CODES);
      3'd2:    off = 17'(2 * e2q_pkg::QUARTER_TURN_CODES);
      3'd3:    off = 17'(3 * e2q_pkg::QUARTER_TURN_CODES);
      default: off = 17'(4 * e2q_pkg::QUARTER_TURN_CODES);
    endcase
  end

  assign r     = signed'({1'b0, u}) - signed'({1'b0, off});
  assign r_abs = r[17] ? -r : r;
  assign mag_d = r_abs[13:0];
  assign neg_d = r[17];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_d;
      neg_q1  <= neg_d;
      quad_q1 <= q4[1:0];
    end
  end

  // stage 2: integer and fractional parts of mag * pi / 46080
  logic [30:0] a_d, a_q;
  logic [27:0] t_d;
  logic [17:0] v_q;

  assign a_d = 31'(mag_q) * 31'(e2q_pkg::PI_INT);
  assign t_d = 28'(mag_q) * 28'(e2q_pkg::PI_FRAC) + 28'(e2q_pkg::HALF_TURN_HALF);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= a_d;
      v_q     <= t_d[27:10];
      neg_q2  <= neg_q1;
      quad_q2 <= quad_q1;
    end
  end

  // stage 3: divide the fractional part by 45 with a reciprocal
  logic [36:0] recip_prod;
  logic [30:0] zmag_q;

  assign recip_prod = 37'(v_q) * 37'(e2q_pkg::RECIP45);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zmag_q  <= a_q + 31'(recip_prod[36:e2q_pkg::RECIP_SH]);
      neg_q3  <= neg_q2;
      quad_q3 <= quad_q2;
    end
  end

  // stage 4: apply the remainder sign
  logic signed [e2q_pkg::Z_W-1:0] zpos;

  assign zpos = signed'(e2q_pkg::Z_W'(zmag_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_o    <= neg_q3 ? -zpos : zpos;
      quad_o <= quad_q3;
    end
  end

endmodule

[hw/rtl/e2q_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic
// Unrolled rotation-mode cordic, one iteration per register stage,
// followed by a registered quarter-turn rotation of the result.
// ----------------------------------------------------------------------------
module e2q_cordic #(
  parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [e2q_pkg::Z_W-1:0]  z_i,
  input  logic [1:0]                      quad_i,
  output e2q_pkg::trig_t                  trig_o
);

  localparam int ZW = e2q_pkg::Z_W;

  logic signed [ZW-1:0] x_q [TRIG_ITERATIONS];
  logic signed [ZW-1:0] y_q [TRIG_ITERATIONS];
  logic signed [ZW-1:0] z_q [TRIG_ITERATIONS];
  logic [1:0]           q_q [TRIG_ITERATIONS];

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_stage
    localparam int K = i % 32;
    logic signed [ZW-1:0] x_cur, y_cur, z_cur, dx, dy, atn;
    logic [1:0]           q_cur;

    // stage input: constant start vector or previous stage
    if (i == 0) begin : g_first
      assign x_cur = ZW'(e2q_pkg::CORDIC_GAIN_Q30);
      assign y_cur = '0;
      assign z_cur = z_i;
      assign q_cur = quad_i;
    end else begin : g_next
      assign x_cur = x_q[i-1];
      assign y_cur = y_q[i-1];
      assign z_cur = z_q[i-1];
      assign q_cur = q_q[i-1];
    end

    assign dx  = y_cur >>> K;
    assign dy  = x_cur >>> K;
    assign atn = ZW'(e2q_pkg::atan_q30(K));

    // one micro-rotation toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_cur[ZW-1]) begin
          x_q[i] <= x_cur - dx;
          y_q[i] <= y_cur + dy;
          z_q[i] <= z_cur - atn;
        end else begin
          x_q[i] <= x_cur + dx;
          y_q[i] <= y_cur - dy;
          z_q[i] <= z_cur + atn;
        end
        q_q[i] <= q_cur;
      end
    end
  end

  // quadrant rotation
  logic signed [e2q_pkg::TRIG_W-1:0] xf, yf;
  e2q_pkg::trig_t                    trig_d;

  assign xf = x_q[TRIG_ITERATIONS-1][e2q_pkg::TRIG_W-1:0];
  assign yf = y_q[TRIG_ITERATIONS-1][e2q_pkg::TRIG_W-1:0];

  always_comb begin
    case (q_q[TRIG_ITERATIONS-1])
      2'd0: begin
        trig_d.c = xf;
        trig_d.s = yf;
      end
      2'd1: begin
        trig_d.c = -yf;
        trig_d.s = xf;
      end
      2'd2: begin
        trig_d.c = -xf;
        trig_d.s = -yf;
      end
      default: begin
        trig_d.c = yf;
        trig_d.s = -xf;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_o <= trig_d;
    end
  end

endmodule

[hw/rtl/e2q_quat_mult.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_quat_mult
// Triple products of half-angle cosines and sines, summed, rounded and
// clamped into the quaternion components. Three register stages.
// ----------------------------------------------------------------------------
module e2q_quat_mult #(
  parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  e2q_pkg::trig_t                      roll_i,
  input  e2q_pkg::trig_t                      pitch_i,
  input  e2q_pkg::trig_t                      yaw_i,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_w_o,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_x_o,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_y_o,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_z_o
);

  localparam int     TW   = e2q_pkg::TRIG_W;
  localparam int     PW   = 34;
  localparam int     SW   = 66;
  localparam int     SH   = 60 - OUT_FRAC_BITS;
  localparam longint HI_L = (OUT_FRAC_BITS >= 15) ? 32767 : (64'sd1 <<< OUT_FRAC_BITS);
  localparam longint LO_L = (OUT_FRAC_BITS >= 15) ? -32768 : -(64'sd1 <<< OUT_FRAC_BITS);
  localparam logic signed [SW-1:0] HI  = SW'(HI_L);
  localparam logic signed [SW-1:0] LO  = SW'(LO_L);
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (SH - 1);

  // stage 1: yaw times roll, rounded back to Q30
  logic signed [63:0]   m_cc, m_ss, m_cs, m_sc;
  logic signed [PW-1:0] p_cc_q, p_ss_q, p_cs_q, p_sc_q;
  logic signed [TW-1:0] cp_q, sp_q;

  assign m_cc = 64'(yaw_i.c) * 64'(roll_i.c);
  assign m_ss = 64'(yaw_i.s) * 64'(roll_i.s);
  assign m_cs = 64'(yaw_i.c) * 64'(roll_i.s);
  assign m_sc = 64'(yaw_i.s) * 64'(roll_i.c);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_cc_q <= PW'((m_cc + 64'sd536870912) >>> 30);
      p_ss_q <= PW'((m_ss + 64'sd536870912) >>> 30);
      p_cs_q <= PW'((m_cs + 64'sd536870912) >>> 30);
      p_sc_q <= PW'((m_sc + 64'sd536870912) >>> 30);
      cp_q   <= pitch_i.c;
      sp_q   <= pitch_i.s;
    end
  end

  // stage 2: third factor, Q60 terms
  logic signed [SW-1:0] w1_q, w2_q, x1_q, x2_q, y1_q, y2_q, z1_q, z2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w1_q <= SW'(p_cc_q) * SW'(cp_q);
      w2_q <= SW'(p_ss_q) * SW'(sp_q);
      x1_q <= SW'(p_cs_q) * SW'(cp_q);
      x2_q <= SW'(p_sc_q) * SW'(sp_q);
      y1_q <= SW'(p_cc_q) * SW'(sp_q);
      y2_q <= SW'(p_ss_q) * SW'(cp_q);
      z1_q <= SW'(p_sc_q) * SW'(cp_q);
      z2_q <= SW'(p_cs_q) * SW'(sp_q);
    end
  end

  // round to the output format and clamp
  function automatic logic signed [e2q_pkg::QUAT_W-1:0] to_out(
    input logic signed [SW-1:0] v
  );
    logic signed [SW-1:0] r;
    r = (v + RND) >>> SH;
    if (r > HI) begin
      r = HI;
    end
    if (r < LO) begin
      r = LO;
    end
    return r[e2q_pkg::QUAT_W-1:0];
  endfunction

  // stage 3: sums into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quat_w_o <= to_out(w1_q + w2_q);
      quat_x_o <= to_out(x1_q - x2_q);
      quat_y_o <= to_out(y1_q + y2_q);
      quat_z_o <= to_out(z1_q - z2_q);
    end
  end

endmodule

[test/euler_to_quaternion_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_core_test
// Drives angle triples through the roll/pitch/yaw to quaternion core and
// checks every quaternion against a bit-exact fixed-point prediction, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module euler_to_quaternion_core_test;

  localparam int ANGLE_W            = e2q_pkg::ANGLE_W;
  localparam int QUAT_W             = e2q_pkg::QUAT_W;
  localparam int FULL_TURN_CODES    = e2q_pkg::FULL_TURN_CODES;
  localparam int QUARTER_TURN_CODES = e2q_pkg::QUARTER_TURN_CODES;
  localparam int EIGHTH_TURN_CODES  = e2q_pkg::EIGHTH_TURN_CODES;
  localparam longint CORDIC_GAIN_Q30 = e2q_pkg::CORDIC_GAIN_Q30;

  localparam int FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF;
  localparam int ITERS     = e2q_pkg::TRIG_ITERATIONS_DEF;
  localparam longint PI_Q30_L  = 64'sd3373259426;
  localparam longint HALF_TURN = 64'sd46080;

  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

  // angle code to half-angle cosine and sine in Q30
  function automatic void half_trig(input longint code, output longint c,
                                    output longint s);
    longint u, q4, r, mag, z, x, y, dx, dy, t;
    int k;
    u = code % FULL_TURN_CODES;
    if (u < 0) u += FULL_TURN_CODES;
    q4 = (u + EIGHTH_TURN_CODES) / QUARTER_TURN_CODES;
    r = u - q4 * QUARTER_TURN_CODES;
    mag = (r < 0) ? -r : r;
    z = (mag * PI_Q30_L + HALF_TURN / 2) / HALF_TURN;
    if (r < 0) z = -z;
    x = CORDIC_GAIN_Q30;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      k = i & 31;
      dx = y >>> k;
      dy = x >>> k;
      t = atan_table(k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= t;
      end else begin
        x += dx; y -= dy; z += t;
      end
    end
    case (q4 & 3)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // own copy of the rounded arctangent table
  function automatic longint atan_table(input int k);
    longint tbl [0:15];
    tbl = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768};
    if (k < 16) return tbl[k];
    if (k >= 31) return 0;
    return longint'(1) << (30 - k);
  endfunction

  function automatic longint prod3(input longint a, input longint b,
                                   input longint c);
    return (((a * b) + (longint'(1) <<< 29)) >>> 30) * c;
  endfunction

  function automatic logic signed [QUAT_W-1:0] to_quat_field(input longint q60);
    longint v, hi, lo;
    v = (q60 + (longint'(1) <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
    hi = longint'(1) << FRAC_BITS;
    lo = -hi;
    if (hi > 32767) hi = 32767;
    if (lo < -32768) lo = -32768;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[QUAT_W-1:0];
  endfunction

  function automatic quat_t predict_quat(input logic signed [ANGLE_W-1:0] ra,
                                         input logic signed [ANGLE_W-1:0] pa,
                                         input logic signed [ANGLE_W-1:0] ya);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_trig(longint'(ra), cr, sr);
    half_trig(longint'(pa), cp, sp);
    half_trig(longint'(ya), cy, sy);
    q.w = to_quat_field(prod3(cy, cr, cp) + prod3(sy, sr, sp));
    q.x = to_quat_field(prod3(cy, sr, cp) - prod3(sy, cr, sp));
    q.y = to_quat_field(prod3(cy, cr, sp) + prod3(sy, sr, cp));
    q.z = to_quat_field(prod3(sy, cr, cp) - prod3(cy, sr, sp));
    return q;
  endfunction

  int mismatch_count = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("  mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // scoreboard of expected quaternions
  class quat_scoreboard;
    quat_t pending_quats[$];

    function void note_angles(logic signed [ANGLE_W-1:0] ra,
                              logic signed [ANGLE_W-1:0] pa,
                              logic signed [ANGLE_W-1:0] ya);
      pending_quats.insert(pending_quats.size(), predict_quat(ra, pa, ya));
    endfunction

    task check_quat(quat_t got);
      quat_t want;
      if (pending_quats.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = pending_quats.pop_front();
        if (got.w !== want.w) report_mismatch("quat_w", got.w, want.w);
        if (got.x !== want.x) report_mismatch("quat_x", got.x, want.x);
        if (got.y !== want.y) report_mismatch("quat_y", got.y, want.y);
        if (got.z !== want.z) report_mismatch("quat_z", got.z, want.z);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [ANGLE_W-1:0] roll_deg_i = '0;
  logic signed [ANGLE_W-1:0] pitch_deg_i = '0;
  logic signed [ANGLE_W-1:0] yaw_deg_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [QUAT_W-1:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;

  euler_to_quaternion_core u_dut (.*);

  quat_scoreboard quat_sb = new();
  bit idling_on = 1'b1;
  bit hold_off_req = 1'b0;
  bit sending_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // input monitor feeds the scoreboard, output monitor checks
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      quat_sb.note_angles(roll_deg_i, pitch_deg_i, yaw_deg_i);
    if (rst_ni && out_valid_o && out_ready_i)
      quat_sb.check_quat({quat_w_o, quat_x_o, quat_y_o, quat_z_o});
  end

  // offer one triple and wait for acceptance, with optional idle burst first
  task automatic send_angles(input logic signed [ANGLE_W-1:0] ra,
                             input logic signed [ANGLE_W-1:0] pa,
                             input logic signed [ANGLE_W-1:0] ya);
    int gap;
    if (idling_on && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(19, 1);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    roll_deg_i <= ra;
    pitch_deg_i <= pa;
    yaw_deg_i <= ya;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    case ($urandom_range(5))
      0: return ANGLE_W'($urandom);                  // any 17-bit code
      1: return ANGLE_W'($urandom_range(11520 + 8) - 4 + 11520 * $urandom_range(7)
                - 46080);                            // random offset within an octant span
      default: return ANGLE_W'($signed($urandom_range(92160)) - 46080);
    endcase
  endfunction

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (idling_on && $urandom_range(3) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(19, 1);
        repeat (stall) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    logic signed [ANGLE_W-1:0] edge_codes[10];
    int waited;
    edge_codes = '{17'sd0, 17'sd46080, -17'sd46080, 17'sd65535, 17'sh10000,
                   17'sd11520, -17'sd11520, 17'sd23040, 17'sd34560, 17'sd1};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, wraps, quadrant boundaries
    foreach (edge_codes[i]) send_angles(edge_codes[i], 17'sd0, 17'sd0);
    foreach (edge_codes[i]) send_angles(17'sd0, edge_codes[i], edge_codes[9 - i]);
    send_angles(17'sd65535, 17'sd65535, 17'sd65535);
    send_angles(17'sh10000, 17'sh10000, 17'sh10000);
    send_angles(17'sd11520, 17'sd11520, 17'sd11520);
    send_angles(-17'sd23040, 17'sd23040, -17'sd46080);

    // random items, with a long receiver hold-off part way
    for (int n = 0; n < 530; n++) begin
      if (n == 150) hold_off_req = 1'b1;
      if (n == 430) idling_on = 1'b0;
      send_angles(rand_angle(), rand_angle(), rand_angle());
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (quat_sb.pending_quats.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && quat_sb.pending_quats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
